>>> hdl/irg_pkg.sv
// ----------------------------------------------------------------------------
// irg_pkg
// Types, codes and helper functions shared by the ISAAC generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package irg_pkg;

    localparam logic [31:0] GOLDEN = 32'h9e3779b9;

    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_INIT = 2'd1,
        FUNC_DRAW = 2'd2
    } func_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INIT,
        ST_PREMIX,
        ST_FILL_MIX,
        ST_FILL_WR,
        ST_SP_RD,
        ST_SP_ADD,
        ST_SP_MIX,
        ST_SP_WR,
        ST_RND_C,
        ST_RND_B,
        ST_RND_RD0,
        ST_RND_X,
        ST_RND_A,
        ST_RND_Y,
        ST_RND_RDY,
        ST_RND_BW,
        ST_RND_END,
        ST_DRAW_CHK,
        ST_DRAW_RD,
        ST_DRAW_OUT
    } state_t;

    typedef enum logic [1:0] {SMR_IDX, SMR_HALF, SMR_X, SMR_Y} sm_rd_sel_t;
    typedef enum logic {SMW_LANE, SMW_Y} sm_wr_sel_t;
    typedef enum logic {RBR_IDX, RBR_DRAW} rb_rd_sel_t;
    typedef enum logic [1:0] {RBW_SEED, RBW_ZERO, RBW_B} rb_wr_sel_t;
    typedef enum logic {ACC_RB, ACC_SM} acc_src_t;
    typedef enum logic [2:0] {
        RND_NONE, RND_INC_C, RND_ADD_B, RND_X, RND_A, RND_Y, RND_B
    } rnd_op_t;

    typedef struct packed {
        logic       init_regs;
        logic       mix_en;
        logic [2:0] mix_line;
        logic       acc_en;
        logic [2:0] acc_lane;
        acc_src_t   acc_src;
        logic       sm_rd_en;
        sm_rd_sel_t sm_rd_sel;
        logic       sm_wr_en;
        sm_wr_sel_t sm_wr_sel;
        logic       rb_rd_en;
        rb_rd_sel_t rb_rd_sel;
        logic       rb_wr_en;
        rb_wr_sel_t rb_wr_sel;
        rnd_op_t    rnd_op;
        logic       out_load;
    } dp_cmd_t;

    // Shift applied in one line of the eight-word mix.
    function automatic logic [31:0] mix_shift(input logic [2:0] line, input logic [31:0] v);
        logic [31:0] r;
        case (line)
            3'd0: r = v << 11;
            3'd1: r = v >> 2;
            3'd2: r = v << 8;
            3'd3: r = v >> 16;
            3'd4: r = v << 10;
            3'd5: r = v >> 4;
            3'd6: r = v << 8;
            3'd7: r = v >> 9;
            default: r = v;
        endcase
        return r;
    endfunction

    // Shift of the accumulator in one generation step, by step position mod 4.
    function automatic logic [31:0] rnd_shift(input logic [1:0] phase, input logic [31:0] a);
        logic [31:0] r;
        case (phase)
            2'd0: r = a << 13;
            2'd1: r = a >> 6;
            2'd2: r = a << 2;
            2'd3: r = a >> 16;
            default: r = a;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/irg_ram.sv
// ----------------------------------------------------------------------------
// irg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module irg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hdl/irg_ctrl.sv
// ----------------------------------------------------------------------------
// irg_ctrl
// Sequencer for seed loads, initialization, buffer refills and draws.
// ----------------------------------------------------------------------------
`default_nettype none

module irg_ctrl #(
    parameter int SIZE_LOG = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_func,
    input  wire logic                s_use_seed,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output irg_pkg::dp_cmd_t         cmd,
    output logic [SIZE_LOG-1:0]      idx,
    output logic [SIZE_LOG-1:0]      draw_addr
);

    localparam logic [SIZE_LOG-1:0] IDX_LAST  = {SIZE_LOG{1'b1}};
    localparam logic [SIZE_LOG-1:0] IDX_ONE   = SIZE_LOG'(1);
    localparam logic [SIZE_LOG-1:0] IDX_SEVEN = SIZE_LOG'(7);
    localparam logic [SIZE_LOG:0]   WL_FULL   = {1'b1, {SIZE_LOG{1'b0}}};
    localparam logic [SIZE_LOG:0]   WL_LAST   = {1'b0, {SIZE_LOG{1'b1}}};
    localparam logic [SIZE_LOG:0]   WL_ONE    = (SIZE_LOG+1)'(1);

    irg_pkg::state_t     state_reg, state_next;
    logic [SIZE_LOG-1:0] idx_reg, idx_next;
    logic [2:0]          line_reg, line_next;
    logic [1:0]          rep_reg, rep_next;
    logic                pass_reg, pass_next;
    logic                seeded_reg, seeded_next;
    logic                draw_reg, draw_next;
    logic                from_init_reg, from_init_next;
    logic                init_done_reg, init_done_next;
    logic [SIZE_LOG:0]   wl_reg, wl_next;
    logic                m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= irg_pkg::ST_CLEAR;
            idx_reg       <= '0;
            line_reg      <= '0;
            rep_reg       <= '0;
            pass_reg      <= 1'b0;
            seeded_reg    <= 1'b0;
            draw_reg      <= 1'b0;
            from_init_reg <= 1'b0;
            init_done_reg <= 1'b0;
            wl_reg        <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            line_reg      <= line_next;
            rep_reg       <= rep_next;
            pass_reg      <= pass_next;
            seeded_reg    <= seeded_next;
            draw_reg      <= draw_next;
            from_init_reg <= from_init_next;
            init_done_reg <= init_done_next;
            wl_reg        <= wl_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        line_next      = line_reg;
        rep_next       = rep_reg;
        pass_next      = pass_reg;
        seeded_next    = seeded_reg;
        draw_next      = draw_reg;
        from_init_next = from_init_reg;
        init_done_next = init_done_reg;
        wl_next        = wl_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        s_ready        = 1'b0;
        cmd            = '0;

        case (state_reg)
            irg_pkg::ST_CLEAR: begin
                cmd.rb_wr_en  = 1'b1;
                cmd.rb_wr_sel = irg_pkg::RBW_ZERO;
                idx_next      = idx_reg + IDX_ONE;
                if (idx_reg == IDX_LAST) begin
                    state_next = irg_pkg::ST_IDLE;
                end
            end
            irg_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_func)
                        irg_pkg::FUNC_LOAD: begin
                            cmd.rb_wr_en  = 1'b1;
                            cmd.rb_wr_sel = irg_pkg::RBW_SEED;
                        end
                        irg_pkg::FUNC_INIT: begin
                            seeded_next = s_use_seed;
                            draw_next   = 1'b0;
                            state_next  = irg_pkg::ST_INIT;
                        end
                        irg_pkg::FUNC_DRAW: begin
                            if (!init_done_reg) begin
                                seeded_next    = 1'b1;
                                draw_next      = 1'b1;
                                init_done_next = 1'b1;
                                state_next     = irg_pkg::ST_INIT;
                            end else begin
                                state_next = irg_pkg::ST_DRAW_CHK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            irg_pkg::ST_INIT: begin
                cmd.init_regs = 1'b1;
                line_next     = '0;
                rep_next      = '0;
                idx_next      = '0;
                state_next    = irg_pkg::ST_PREMIX;
            end
            irg_pkg::ST_PREMIX: begin
                cmd.mix_en   = 1'b1;
                cmd.mix_line = line_reg;
                line_next    = line_reg + 3'd1;
                if (line_reg == 3'd7) begin
                    rep_next = rep_reg + 2'd1;
                    if (rep_reg == 2'd3) begin
                        state_next = irg_pkg::ST_FILL_MIX;
                    end
                end
            end
            irg_pkg::ST_FILL_MIX: begin
                cmd.mix_en   = 1'b1;
                cmd.mix_line = line_reg;
                line_next    = line_reg + 3'd1;
                if (line_reg == 3'd7) begin
                    state_next = irg_pkg::ST_FILL_WR;
                end
            end
            irg_pkg::ST_FILL_WR: begin
                cmd.sm_wr_en  = 1'b1;
                cmd.sm_wr_sel = irg_pkg::SMW_LANE;
                idx_next      = idx_reg + IDX_ONE;
                if (idx_reg[2:0] == 3'd7) begin
                    if (idx_reg == IDX_LAST) begin
                        pass_next = 1'b0;
                        if (seeded_reg) begin
                            state_next = irg_pkg::ST_SP_RD;
                        end else begin
                            from_init_next = 1'b1;
                            state_next     = irg_pkg::ST_RND_C;
                        end
                    end else begin
                        state_next = irg_pkg::ST_FILL_MIX;
                    end
                end
            end
            irg_pkg::ST_SP_RD: begin
                // Reads run ahead of the lane they are added into: each word is added in the cycle after its read.
                cmd.acc_src = pass_reg ? irg_pkg::ACC_SM : irg_pkg::ACC_RB;
                if (pass_reg) begin
                    cmd.sm_rd_en  = 1'b1;
                    cmd.sm_rd_sel = irg_pkg::SMR_IDX;
                end else begin
                    cmd.rb_rd_en  = 1'b1;
                    cmd.rb_rd_sel = irg_pkg::RBR_IDX;
                end
                if (idx_reg[2:0] != 3'd0) begin
                    cmd.acc_en   = 1'b1;
                    cmd.acc_lane = idx_reg[2:0] - 3'd1;
                end
                if (idx_reg[2:0] == 3'd7) begin
                    idx_next   = idx_reg & ~IDX_SEVEN;
                    state_next = irg_pkg::ST_SP_ADD;
                end else begin
                    idx_next = idx_reg + IDX_ONE;
                end
            end
            irg_pkg::ST_SP_ADD: begin
                cmd.acc_src  = pass_reg ? irg_pkg::ACC_SM : irg_pkg::ACC_RB;
                cmd.acc_en   = 1'b1;
                cmd.acc_lane = 3'd7;
                state_next   = irg_pkg::ST_SP_MIX;
            end
            irg_pkg::ST_SP_MIX: begin
                cmd.mix_en   = 1'b1;
                cmd.mix_line = line_reg;
                line_next    = line_reg + 3'd1;
                if (line_reg == 3'd7) begin
                    state_next = irg_pkg::ST_SP_WR;
                end
            end
            irg_pkg::ST_SP_WR: begin
                cmd.sm_wr_en  = 1'b1;
                cmd.sm_wr_sel = irg_pkg::SMW_LANE;
                idx_next      = idx_reg + IDX_ONE;
                if (idx_reg[2:0] == 3'd7) begin
                    if (idx_reg == IDX_LAST) begin
                        if (!pass_reg) begin
                            pass_next  = 1'b1;
                            state_next = irg_pkg::ST_SP_RD;
                        end else begin
                            from_init_next = 1'b1;
                            state_next     = irg_pkg::ST_RND_C;
                        end
                    end else begin
                        state_next = irg_pkg::ST_SP_RD;
                    end
                end
            end
            irg_pkg::ST_RND_C: begin
                cmd.rnd_op = irg_pkg::RND_INC_C;
                idx_next   = '0;
                state_next = irg_pkg::ST_RND_B;
            end
            irg_pkg::ST_RND_B: begin
                cmd.rnd_op = irg_pkg::RND_ADD_B;
                state_next = irg_pkg::ST_RND_RD0;
            end
            irg_pkg::ST_RND_RD0: begin
                cmd.sm_rd_en  = 1'b1;
                cmd.sm_rd_sel = irg_pkg::SMR_IDX;
                state_next    = irg_pkg::ST_RND_X;
            end
            irg_pkg::ST_RND_X: begin
                cmd.rnd_op    = irg_pkg::RND_X;
                cmd.sm_rd_en  = 1'b1;
                cmd.sm_rd_sel = irg_pkg::SMR_HALF;
                state_next    = irg_pkg::ST_RND_A;
            end
            irg_pkg::ST_RND_A: begin
                cmd.rnd_op    = irg_pkg::RND_A;
                cmd.sm_rd_en  = 1'b1;
                cmd.sm_rd_sel = irg_pkg::SMR_X;
                state_next    = irg_pkg::ST_RND_Y;
            end
            irg_pkg::ST_RND_Y: begin
                cmd.rnd_op    = irg_pkg::RND_Y;
                cmd.sm_wr_en  = 1'b1;
                cmd.sm_wr_sel = irg_pkg::SMW_Y;
                state_next    = irg_pkg::ST_RND_RDY;
            end
            irg_pkg::ST_RND_RDY: begin
                // The read follows the write, so it sees the new word when the
                // indirect address lands on the current entry.
                cmd.sm_rd_en  = 1'b1;
                cmd.sm_rd_sel = irg_pkg::SMR_Y;
                state_next    = irg_pkg::ST_RND_BW;
            end
            irg_pkg::ST_RND_BW: begin
                cmd.rnd_op    = irg_pkg::RND_B;
                cmd.rb_wr_en  = 1'b1;
                cmd.rb_wr_sel = irg_pkg::RBW_B;
                idx_next      = idx_reg + IDX_ONE;
                if (idx_reg == IDX_LAST) begin
                    state_next = irg_pkg::ST_RND_END;
                end else begin
                    state_next = irg_pkg::ST_RND_RD0;
                end
            end
            irg_pkg::ST_RND_END: begin
                if (from_init_reg) begin
                    from_init_next = 1'b0;
                    wl_next        = WL_FULL;
                    if (draw_reg) begin
                        draw_next  = 1'b0;
                        state_next = irg_pkg::ST_DRAW_CHK;
                    end else begin
                        state_next = irg_pkg::ST_IDLE;
                    end
                end else begin
                    wl_next    = WL_LAST;
                    state_next = irg_pkg::ST_DRAW_RD;
                end
            end
            irg_pkg::ST_DRAW_CHK: begin
                if (wl_reg == '0) begin
                    from_init_next = 1'b0;
                    state_next     = irg_pkg::ST_RND_C;
                end else begin
                    wl_next    = wl_reg - WL_ONE;
                    state_next = irg_pkg::ST_DRAW_RD;
                end
            end
            irg_pkg::ST_DRAW_RD: begin
                cmd.rb_rd_en  = 1'b1;
                cmd.rb_rd_sel = irg_pkg::RBR_DRAW;
                state_next    = irg_pkg::ST_DRAW_OUT;
            end
            irg_pkg::ST_DRAW_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = irg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = irg_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign idx       = idx_reg;
    assign draw_addr = wl_reg[SIZE_LOG-1:0];

endmodule

`default_nettype wire

>>> hdl/irg_dpath.sv
// ----------------------------------------------------------------------------
// irg_dpath
// Mixing lanes, generator accumulators, state memory and result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module irg_dpath #(
    parameter int SIZE_LOG = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire irg_pkg::dp_cmd_t    cmd,
    input  wire logic [SIZE_LOG-1:0] idx,
    input  wire logic [SIZE_LOG-1:0] draw_addr,
    input  wire logic [7:0]          seed_index,
    input  wire logic [31:0]         seed_word,
    output logic [31:0]              random_word
);

    localparam int DEPTH = 1 << SIZE_LOG;
    localparam logic [SIZE_LOG-1:0] IDX_HALF = {1'b1, {(SIZE_LOG-1){1'b0}}};

    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic [31:0] x_reg, x_next, y_reg, y_next;
    logic [31:0] out_reg;

    logic [31:0]         sm_rd_data, rb_rd_data, sm_wr_data, rb_wr_data, acc_data;
    logic [SIZE_LOG-1:0] sm_rd_addr, rb_rd_addr, rb_wr_addr;
    logic [SIZE_LOG+7:0] seed_ext;
    logic [2:0]          j1, j2, j3;
    logic [31:0]         mix_val;

    assign seed_ext = {{SIZE_LOG{1'b0}}, seed_index};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
        end else begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 8; k++) begin
            v_reg[k] <= v_next[k];
        end
        x_reg <= x_next;
        y_reg <= y_next;
        if (cmd.out_load) begin
            out_reg <= rb_rd_data;
        end
    end

    // One line of the eight-word mix per cycle while mix_en is set; also the lane load of GOLDEN and the lane add.
    always_comb begin
        j1       = cmd.mix_line + 3'd1;
        j2       = cmd.mix_line + 3'd2;
        j3       = cmd.mix_line + 3'd3;
        mix_val  = v_reg[cmd.mix_line] ^ irg_pkg::mix_shift(cmd.mix_line, v_reg[j1]);
        acc_data = (cmd.acc_src == irg_pkg::ACC_SM) ? sm_rd_data : rb_rd_data;
        for (int k = 0; k < 8; k++) begin
            v_next[k] = v_reg[k];
        end
        if (cmd.init_regs) begin
            for (int k = 0; k < 8; k++) begin
                v_next[k] = irg_pkg::GOLDEN;
            end
        end
        if (cmd.mix_en) begin
            v_next[cmd.mix_line] = mix_val;
            v_next[j3]           = v_reg[j3] + mix_val;
            v_next[j1]           = v_reg[j1] + v_reg[j2];
        end
        if (cmd.acc_en) begin
            v_next[cmd.acc_lane] = v_reg[cmd.acc_lane] + acc_data;
        end
    end

    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        x_next = x_reg;
        y_next = y_reg;
        if (cmd.init_regs) begin
            a_next = '0;
            b_next = '0;
            c_next = '0;
        end
        case (cmd.rnd_op)
            irg_pkg::RND_INC_C: c_next = c_reg + 32'd1;
            irg_pkg::RND_ADD_B: b_next = b_reg + c_reg;
            irg_pkg::RND_X:     x_next = sm_rd_data;
            irg_pkg::RND_A:     a_next = (a_reg ^ irg_pkg::rnd_shift(idx[1:0], a_reg))
                                         + sm_rd_data;
            irg_pkg::RND_Y:     y_next = sm_rd_data + a_reg + b_reg;
            irg_pkg::RND_B:     b_next = sm_rd_data + x_reg;
            default: begin
            end
        endcase
    end

    always_comb begin
        case (cmd.sm_rd_sel)
            irg_pkg::SMR_IDX:  sm_rd_addr = idx;
            irg_pkg::SMR_HALF: sm_rd_addr = idx + IDX_HALF;
            irg_pkg::SMR_X:    sm_rd_addr = x_reg[SIZE_LOG+1:2];
            irg_pkg::SMR_Y:    sm_rd_addr = y_reg[2*SIZE_LOG+1:SIZE_LOG+2];
            default:           sm_rd_addr = idx;
        endcase
        sm_wr_data = (cmd.sm_wr_sel == irg_pkg::SMW_Y) ? y_next : v_reg[idx[2:0]];
        rb_rd_addr = (cmd.rb_rd_sel == irg_pkg::RBR_DRAW) ? draw_addr : idx;
        case (cmd.rb_wr_sel)
            irg_pkg::RBW_SEED: begin
                rb_wr_addr = seed_ext[SIZE_LOG-1:0];
                rb_wr_data = seed_word;
            end
            irg_pkg::RBW_ZERO: begin
                rb_wr_addr = idx;
                rb_wr_data = '0;
            end
            irg_pkg::RBW_B: begin
                rb_wr_addr = idx;
                rb_wr_data = b_next;
            end
            default: begin
                rb_wr_addr = idx;
                rb_wr_data = '0;
            end
        endcase
    end

    irg_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_state_mem (
        .aclk    (aclk),
        .wr_en   (cmd.sm_wr_en),
        .wr_addr (idx),
        .wr_data (sm_wr_data),
        .rd_en   (cmd.sm_rd_en),
        .rd_addr (sm_rd_addr),
        .rd_data (sm_rd_data)
    );

    irg_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_result_buf (
        .aclk    (aclk),
        .wr_en   (cmd.rb_wr_en),
        .wr_addr (rb_wr_addr),
        .wr_data (rb_wr_data),
        .rd_en   (cmd.rb_rd_en),
        .rd_addr (rb_rd_addr),
        .rd_data (rb_rd_data)
    );

    assign random_word = out_reg;

endmodule

`default_nettype wire

>>> hdl/isaac_random_generator.sv
// ----------------------------------------------------------------------------
// isaac_random_generator
// 32-bit ISAAC generator with a state memory and a result buffer in RAM.
// ----------------------------------------------------------------------------
// Each input transaction carries a function code: load one seed word into the
// result buffer, initialize the generator (optionally mixing in the buffer as
// seed), or draw one word. Only draws produce an output transaction.
// A draw served from the buffer checks the fill level, reads the buffer and
// loads the output register. When the buffer is empty, a refill of the
// buffer runs first, one word at a time through the state memory. An
// initialize runs the unseeded fill, plus two seeded passes in groups of
// eight words when seeding, and then one refill.
// The first draw after reset runs a seeded initialization before it.
// After reset the result buffer is cleared, one entry a cycle, while s_ready
// is low. One transaction is worked on at a time.
// The result waits in an output register; while m_ready is low the block
// still accepts loads and initializes, and a further draw holds until the
// register has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module isaac_random_generator #(
    parameter int SIZE_LOG = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [7:0]  s_seed_index,
    input  wire logic [31:0] s_seed_word,
    input  wire logic        s_use_seed,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_random_word
);

    irg_pkg::dp_cmd_t    cmd;
    logic [SIZE_LOG-1:0] idx;
    logic [SIZE_LOG-1:0] draw_addr;

    irg_ctrl #(.SIZE_LOG(SIZE_LOG)) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_use_seed (s_use_seed),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .idx        (idx),
        .draw_addr  (draw_addr)
    );

    irg_dpath #(.SIZE_LOG(SIZE_LOG)) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .idx         (idx),
        .draw_addr   (draw_addr),
        .seed_index  (s_seed_index),
        .seed_word   (s_seed_word),
        .random_word (m_random_word)
    );

endmodule

`default_nettype wire
